// ----- src/pfqm_pkg.sv -----
// Package for the per-flow packet queue manager.
// Types, codes and field widths shared by the core; no dependencies.
`default_nettype none

package pfqm_pkg;

  localparam int FLOW_ID_W = 8;
  localparam int HANDLE_W  = 10;
  localparam int COUNT_W   = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_ISSUE  = 1'b1;

  localparam logic FLOW_IDLE      = 1'b0;
  localparam logic FLOW_RECEIVING = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FLOW,
    ST_LINK
  } state_t;

  // One word of the flow table.
  typedef struct packed {
    logic                state;
    logic [COUNT_W-1:0]  count;
    logic [HANDLE_W-1:0] head;
    logic [HANDLE_W-1:0] tail;
  } flow_entry_t;

endpackage

`default_nettype wire

// ----- src/pfqm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module pfqm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/per_flow_packet_queue_manager_core.sv -----
// Channel | valid     | stall     | payload
// --------+-----------+-----------+---------------------------------------------------
// req     | req_valid | req_stall | command, flow_id, pkt_handle
// rsp     | rsp_valid | rsp_stall | flow_state, found, out_handle, pending_count
//
// One item at a time. Insert and issue of an empty queue take one flow table read; an issue
// that finds a handle takes one flow table read, then one link memory read for the
// next head. A stalled result holds the item in its last step until the slot frees.
// After reset a clearing pass writes every flow entry, with
// req_stall high. Depends on pfqm_pkg and pfqm_ram.
`default_nettype none

module per_flow_packet_queue_manager_core #(
  parameter int NUM_FLOWS   = 256,
  parameter int NUM_BUFFERS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic                           command,
  input  wire logic [pfqm_pkg::FLOW_ID_W-1:0] flow_id,
  input  wire logic [pfqm_pkg::HANDLE_W-1:0]  pkt_handle,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic                                flow_state,
  output logic                                found,
  output logic      [pfqm_pkg::HANDLE_W-1:0]  out_handle,
  output logic      [pfqm_pkg::COUNT_W-1:0]   pending_count
);

  localparam int FW = $clog2(NUM_FLOWS);
  localparam int BW = $clog2(NUM_BUFFERS);
  localparam int EW = $bits(pfqm_pkg::flow_entry_t);

  // Reduce a narrow value modulo a constant by shifted conditional subtracts.
  function automatic logic [15:0] mod_reduce(input logic [15:0] v, input int unsigned m);
    logic [31:0] r;
    r = 32'(v);
    for (int k = 9; k >= 0; k--) begin
      if (r >= (32'(m) << k)) begin
        r = r - (32'(m) << k);
      end
    end
    return r[15:0];
  endfunction

  pfqm_pkg::state_t state, state_next;

  logic [FW-1:0]                  clr_addr;
  logic                           clr_last;
  logic                           cmd;
  logic [FW-1:0]                  fidx;
  logic [pfqm_pkg::HANDLE_W-1:0]  handle;

  logic                           accept;
  logic                           out_free;
  logic                           commit;
  logic                           needs_link;
  logic [FW-1:0]                  fidx_in;

  logic                           flow_we;
  logic [FW-1:0]                  flow_waddr;
  logic [EW-1:0]                  flow_wdata;
  logic                           flow_re;
  logic [EW-1:0]                  flow_rdata;
  pfqm_pkg::flow_entry_t          cur;
  pfqm_pkg::flow_entry_t          upd;

  logic                           link_we;
  logic [BW-1:0]                  link_waddr;
  logic                           link_re;
  logic [BW-1:0]                  link_raddr;
  logic [pfqm_pkg::HANDLE_W-1:0]  link_rdata;

  logic                           res_state;
  logic                           res_found;
  logic [pfqm_pkg::HANDLE_W-1:0]  res_handle;

  assign req_stall = (state != pfqm_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign clr_last  = (clr_addr == FW'(NUM_FLOWS - 1));
  assign fidx_in   = FW'(mod_reduce(16'(flow_id), NUM_FLOWS));
  assign cur       = pfqm_pkg::flow_entry_t'(flow_rdata);
  assign needs_link = (cmd == pfqm_pkg::CMD_ISSUE) && (cur.count != '0);

  pfqm_ram #(.WIDTH(EW), .DEPTH(NUM_FLOWS)) u_flow_ram (
    .clk   (clk),
    .we    (flow_we),
    .waddr (flow_waddr),
    .wdata (flow_wdata),
    .re    (flow_re),
    .raddr (fidx_in),
    .rdata (flow_rdata)
  );

  pfqm_ram #(.WIDTH(pfqm_pkg::HANDLE_W), .DEPTH(NUM_BUFFERS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (handle),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfqm_pkg::ST_CLEAR: begin
        if (clr_last) state_next = pfqm_pkg::ST_IDLE;
      end
      pfqm_pkg::ST_IDLE: begin
        if (req_valid) state_next = pfqm_pkg::ST_FLOW;
      end
      pfqm_pkg::ST_FLOW: begin
        if (needs_link) begin
          state_next = pfqm_pkg::ST_LINK;
        end else if (out_free) begin
          state_next = pfqm_pkg::ST_IDLE;
        end
      end
      pfqm_pkg::ST_LINK: begin
        if (out_free) state_next = pfqm_pkg::ST_IDLE;
      end
      default: state_next = pfqm_pkg::ST_CLEAR;
    endcase
  end

  // memory control and result
  always_comb begin
    flow_re    = accept;
    link_re    = 1'b0;
    link_raddr = BW'(mod_reduce(16'(cur.head), NUM_BUFFERS));
    link_we    = 1'b0;
    link_waddr = BW'(mod_reduce(16'(cur.tail), NUM_BUFFERS));
    commit     = 1'b0;
    flow_we    = 1'b0;
    flow_waddr = fidx;
    upd        = cur;
    res_state  = cur.state;
    res_found  = 1'b0;
    res_handle = '0;
    case (state)
      pfqm_pkg::ST_CLEAR: begin
        flow_we    = 1'b1;
        flow_waddr = clr_addr;
        upd        = '0;
      end
      pfqm_pkg::ST_FLOW: begin
        link_re = needs_link;
        commit  = !needs_link && out_free;
        if (cmd == pfqm_pkg::CMD_INSERT) begin
          // empty queue: handle becomes head, no link written
          if (cur.count == '0) begin
            upd.head = handle;
          end
          upd.tail  = handle;
          upd.state = pfqm_pkg::FLOW_RECEIVING;
          if (cur.count != pfqm_pkg::COUNT_MAX) begin
            upd.count = cur.count + 1'b1;
          end
          res_state = pfqm_pkg::FLOW_RECEIVING;
          flow_we   = commit;
          link_we   = commit && (cur.count != '0);
        end
      end
      pfqm_pkg::ST_LINK: begin
        commit     = out_free;
        flow_we    = out_free;
        upd.head   = link_rdata;
        upd.count  = cur.count - 1'b1;
        res_found  = 1'b1;
        res_handle = cur.head;
      end
      default: begin
      end
    endcase
    flow_wdata = EW'(upd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfqm_pkg::ST_CLEAR;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pfqm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= command;
      fidx   <= fidx_in;
      handle <= pkt_handle;
    end
    if (commit) begin
      flow_state    <= res_state;
      found         <= res_found;
      out_handle    <= res_handle;
      pending_count <= upd.count;
    end
  end

endmodule

`default_nettype wire

// ----- bench/pfqm_checker.sv -----
// Result checker for the per-flow packet queue manager: watches both channels,
// keeps its own copy of the flow tables and link memory, compares each result.
// Depends on pfqm_pkg.
module pfqm_checker #(
  parameter int NUM_FLOWS   = 256,
  parameter int NUM_BUFFERS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic                           command,
  input  logic [pfqm_pkg::FLOW_ID_W-1:0] flow_id,
  input  logic [pfqm_pkg::HANDLE_W-1:0]  pkt_handle,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  logic                           flow_state,
  input  logic                           found,
  input  logic [pfqm_pkg::HANDLE_W-1:0]  out_handle,
  input  logic [pfqm_pkg::COUNT_W-1:0]   pending_count,
  output int                             mismatches,
  output int                             awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          state;
    logic                          hit;
    logic [pfqm_pkg::HANDLE_W-1:0] handle;
    logic [pfqm_pkg::COUNT_W-1:0]  count;
  } queue_result_t;

  logic [pfqm_pkg::HANDLE_W-1:0] head_of  [NUM_FLOWS];
  logic [pfqm_pkg::HANDLE_W-1:0] tail_of  [NUM_FLOWS];
  logic [pfqm_pkg::COUNT_W-1:0]  depth_of [NUM_FLOWS];
  logic                          state_of [NUM_FLOWS];
  logic [pfqm_pkg::HANDLE_W-1:0] next_of  [NUM_BUFFERS];

  queue_result_t results_due[$];

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  // Applies one request to the shadow tables and returns the result it gives.
  function automatic queue_result_t queue_step(logic cmd, logic [pfqm_pkg::FLOW_ID_W-1:0] f,
                                               logic [pfqm_pkg::HANDLE_W-1:0] h);
    queue_result_t r;
    r = '0;
    if (cmd == pfqm_pkg::CMD_INSERT) begin
      if (depth_of[f] == '0) head_of[f] = h;
      else next_of[tail_of[f]] = h;
      tail_of[f] = h;
      if (depth_of[f] != pfqm_pkg::COUNT_MAX) depth_of[f] = depth_of[f] + 1'b1;
      state_of[f] = pfqm_pkg::FLOW_RECEIVING;
    end else if (depth_of[f] != '0) begin
      r.hit       = 1'b1;
      r.handle    = head_of[f];
      head_of[f]  = next_of[head_of[f]];
      depth_of[f] = depth_of[f] - 1'b1;
    end
    r.state = state_of[f];
    r.count = depth_of[f];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [pfqm_pkg::COUNT_W-1:0] want,
                             input logic [pfqm_pkg::COUNT_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("checker: %s mismatch at %0t, expected %0d, got %0d", name, $realtime,
                 want, got);
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      for (int k = 0; k < NUM_FLOWS; k++) begin
        head_of[k]  = '0;
        tail_of[k]  = '0;
        depth_of[k] = '0;
        state_of[k] = pfqm_pkg::FLOW_IDLE;
      end
      for (int k = 0; k < NUM_BUFFERS; k++) next_of[k] = '0;
      results_due.delete();
    end else begin
      // result first: one accepted in this cycle belongs to an older item
      if (rsp_valid && !rsp_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("checker: result at %0t with none expected", $realtime);
        end else begin
          want = results_due.pop_front();
          check_field("flow_state", pfqm_pkg::COUNT_W'(want.state),
                      pfqm_pkg::COUNT_W'(flow_state));
          check_field("found", pfqm_pkg::COUNT_W'(want.hit), pfqm_pkg::COUNT_W'(found));
          check_field("out_handle", pfqm_pkg::COUNT_W'(want.handle),
                      pfqm_pkg::COUNT_W'(out_handle));
          check_field("pending_count", want.count, pending_count);
        end
      end
      if (req_valid && !req_stall)
        results_due.push_back(queue_step(command, flow_id, pkt_handle));
    end
    awaited = results_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the queue manager bench: clock, reset, item stimulus and the verdict.
// Instantiates per_flow_packet_queue_manager_core and pfqm_checker; uses pfqm_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FLOWS   = 256;
  localparam int NUM_BUFFERS = 1024;

  logic                           clk;
  logic                           rst;
  logic                           req_valid;
  logic                           req_stall;
  logic                           command;
  logic [pfqm_pkg::FLOW_ID_W-1:0] flow_id;
  logic [pfqm_pkg::HANDLE_W-1:0]  pkt_handle;
  logic                           rsp_valid;
  logic                           rsp_stall;
  logic                           flow_state;
  logic                           found;
  logic [pfqm_pkg::HANDLE_W-1:0]  out_handle;
  logic [pfqm_pkg::COUNT_W-1:0]   pending_count;
  int                             mismatches;
  int                             awaited;

  // what the stimulus side knows of each flow, to keep sequences well formed
  logic [pfqm_pkg::HANDLE_W-1:0] queued [NUM_FLOWS][$];
  bit                            linked [NUM_BUFFERS];
  bit                            busy   [NUM_BUFFERS];
  int                            live;

  int send_idle_pct;
  int stall_pct;
  bit hold_request;
  int hold_left;

  per_flow_packet_queue_manager_core #(
    .NUM_FLOWS  (NUM_FLOWS),
    .NUM_BUFFERS(NUM_BUFFERS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .command      (command),
    .flow_id      (flow_id),
    .pkt_handle   (pkt_handle),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .flow_state   (flow_state),
    .found        (found),
    .out_handle   (out_handle),
    .pending_count(pending_count)
  );

  pfqm_checker #(
    .NUM_FLOWS  (NUM_FLOWS),
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .command      (command),
    .flow_id      (flow_id),
    .pkt_handle   (pkt_handle),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .flow_state   (flow_state),
    .found        (found),
    .out_handle   (out_handle),
    .pending_count(pending_count),
    .mismatches   (mismatches),
    .awaited      (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    rsp_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 250;
        rsp_stall   <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_item(input logic c, input logic [pfqm_pkg::FLOW_ID_W-1:0] f,
                           input logic [pfqm_pkg::HANDLE_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    command    <= c;
    flow_id    <= f;
    pkt_handle <= h;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (c == pfqm_pkg::CMD_INSERT) begin
      if (queued[f].size() != 0) linked[queued[f][$]] = 1'b1;
      queued[f].push_back(h);
      busy[h] = 1'b1;
      live++;
    end else if (queued[f].size() != 0) begin
      busy[queued[f].pop_front()] = 1'b0;
      live--;
    end
  endtask

  // Mostly traffic on a few busy flows, some on any flow. An issue never drains
  // a flow whose last handle has no link entry yet; that becomes an insert.
  task automatic run_phase(input int n, input int idle_pct, input int stall_p);
    logic [pfqm_pkg::FLOW_ID_W-1:0] hot [6];
    logic [pfqm_pkg::FLOW_ID_W-1:0] f;
    logic [pfqm_pkg::HANDLE_W-1:0]  h;
    bit                             do_insert;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    foreach (hot[k]) hot[k] = pfqm_pkg::FLOW_ID_W'($urandom_range(NUM_FLOWS - 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) f = hot[$urandom_range(5)];
      else f = pfqm_pkg::FLOW_ID_W'($urandom_range(NUM_FLOWS - 1));
      do_insert = ($urandom_range(99) < ((live > 600) ? 30 : 52));
      if (!do_insert && queued[f].size() == 1 && !linked[queued[f][0]]) do_insert = 1'b1;
      if (do_insert) begin
        do h = pfqm_pkg::HANDLE_W'($urandom_range(NUM_BUFFERS - 1)); while (busy[h]);
        send_item(pfqm_pkg::CMD_INSERT, f, h);
      end else begin
        send_item(pfqm_pkg::CMD_ISSUE, f,
                  pfqm_pkg::HANDLE_W'($urandom_range(NUM_BUFFERS - 1)));
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    command       = pfqm_pkg::CMD_INSERT;
    flow_id       = '0;
    pkt_handle    = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    live          = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty issues, extremes, drain and refill, a repeated handle
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'd0);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd255, 10'h3FF);
    send_item(pfqm_pkg::CMD_INSERT, 8'd0,   10'd0);
    send_item(pfqm_pkg::CMD_INSERT, 8'd0,   10'h3FF);
    send_item(pfqm_pkg::CMD_INSERT, 8'd0,   10'h155);
    send_item(pfqm_pkg::CMD_INSERT, 8'd255, 10'h2AA);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'h2AA);
    send_item(pfqm_pkg::CMD_INSERT, 8'd0,   10'd0);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'h155);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'd0);
    send_item(pfqm_pkg::CMD_INSERT, 8'd255, 10'h3FF);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd255, 10'd0);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'h3FF);
    // drained flow stays receiving
    send_item(pfqm_pkg::CMD_ISSUE,  8'd0,   10'd0);
    send_item(pfqm_pkg::CMD_INSERT, 8'd0,   10'h2AA);
    send_item(pfqm_pkg::CMD_INSERT, 8'd7,   10'd5);
    send_item(pfqm_pkg::CMD_INSERT, 8'd7,   10'd5);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd7,   10'd0);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd7,   10'd0);
    send_item(pfqm_pkg::CMD_ISSUE,  8'd255, 10'd0);

    run_phase(300, 0, 0);
    run_phase(300, 72, 0);
    run_phase(300, 0, 72);
    run_phase(300, 11, 11);
    // long receiver hold-off while the sender keeps offering items
    hold_request = 1'b1;
    run_phase(330, 0, 0);
    req_valid <= 1'b0;

    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- per_flow_packet_queue_manager_core.f -----
src/pfqm_pkg.sv
src/pfqm_ram.sv
src/per_flow_packet_queue_manager_core.sv
bench/pfqm_checker.sv
bench/testbench.sv
